// ===== rtl/bfd_pkg.sv =====
// Shared types, constants and the divider reciprocal table for the box filter downsampler.
// No dependencies; every other file in rtl/ except bfd_ram uses this package.
`default_nettype none

package bfd_pkg;

    localparam int MAX_OUT_WIDTH = 256;
    localparam int COL_W         = $clog2(MAX_OUT_WIDTH);
    localparam int MAX_FACTOR    = 8;
    localparam int FAC_W         = 4;
    localparam int SUB_W         = $clog2(MAX_FACTOR);
    localparam int NUM_CH        = 3;
    localparam int PIX_W         = 8;
    localparam int SUM_W         = 14;
    localparam int SUM_ALL_W     = NUM_CH * SUM_W;
    localparam int MAX_SIDE      = 2048;
    localparam int POS_W         = $clog2(MAX_SIDE);
    localparam int CFG_W         = 12;
    localparam int CFG_IDX_W     = 2;

    // floor(n / d) == (n * ceil(2^20 / d)) >> 20 for n < 2^14, d <= 64
    localparam int RECIP_SHIFT   = 20;
    localparam int RECIP_W       = RECIP_SHIFT + 1;
    localparam int PROD_W        = SUM_W + RECIP_W;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [FAC_W-1:0] FACTOR_RESET = 4'd3;
    localparam logic [CFG_W-1:0] SIDE_RESET   = 12'd96;

    // Per-word control carried alongside the pixel through the pipe.
    typedef struct packed {
        logic             act;        // block column is inside the accumulator range
        logic             last;       // bottom-right pixel of its block
        logic             frame_last; // last pixel of the frame
        logic             clear;      // block row ends: all accumulators drop to zero
        logic [COL_W-1:0] col;        // output column
    } t_tag;

    // Reciprocal of factor squared, scaled by 2^RECIP_SHIFT and rounded up.
    function automatic logic [RECIP_W-1:0] recip_of(input logic [FAC_W-1:0] f);
        logic [RECIP_W-1:0] r;
        case (f)
            4'd1:    r = 21'd1048576;
            4'd2:    r = 21'd262144;
            4'd3:    r = 21'd116509;
            4'd4:    r = 21'd65536;
            4'd5:    r = 21'd41944;
            4'd6:    r = 21'd29128;
            4'd7:    r = 21'd21400;
            4'd8:    r = 21'd16384;
            default: r = 21'd1048576;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bfd_pix_if.sv =====
// Input channel: one source pixel per word, valid/ready handshake.
// Uses bfd_pkg for field widths.
`default_nettype none

interface bfd_pix_if;
    logic                        valid;
    logic                        ready;
    logic [bfd_pkg::PIX_W-1:0]   pixel_red;
    logic [bfd_pkg::PIX_W-1:0]   pixel_green;
    logic [bfd_pkg::PIX_W-1:0]   pixel_blue;

    modport source (output valid, output pixel_red, output pixel_green, output pixel_blue,
                    input ready);
    modport sink   (input valid, input pixel_red, input pixel_green, input pixel_blue,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/bfd_avg_if.sv =====
// Output channel: one block average per word plus end-of-frame mark.
// Uses bfd_pkg for field widths.
`default_nettype none

interface bfd_avg_if;
    logic                        valid;
    logic                        ready;
    logic [bfd_pkg::PIX_W-1:0]   avg_red;
    logic [bfd_pkg::PIX_W-1:0]   avg_green;
    logic [bfd_pkg::PIX_W-1:0]   avg_blue;
    logic                        frame_end;

    modport source (output valid, output avg_red, output avg_green, output avg_blue,
                    output frame_end, input ready);
    modport sink   (input valid, input avg_red, input avg_green, input avg_blue,
                    input frame_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/bfd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No package dependency.
`default_nettype none

module bfd_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/bfd_ctrl.sv =====
// Configuration registers and raster position counters; tags each accepted word.
// Depends on bfd_pkg.
`default_nettype none

module bfd_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bfd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bfd_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_step,
    output bfd_pkg::t_tag                  o_tag,
    output logic [bfd_pkg::FAC_W-1:0]      o_factor
);
    import bfd_pkg::*;

    logic [FAC_W-1:0] r_factor;
    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;

    logic [POS_W-1:0] r_src_col;
    logic [POS_W-1:0] r_src_row;
    logic [SUB_W-1:0] r_sub_col;
    logic [SUB_W-1:0] r_sub_row;
    logic [COL_W-1:0] r_out_col;
    logic             r_out_over;

    logic [FAC_W-1:0] fac;
    logic [SUB_W-1:0] fac_m1;
    logic [POS_W-1:0] w_m1;
    logic [POS_W-1:0] h_m1;
    logic             col_last;
    logic             row_last;
    logic             line_end;
    logic             frame_last;

    // out-of-range settings are clamped to the legal range
    always_comb begin
        if (r_factor == '0) begin
            fac = FAC_W'(1);
        end else if (r_factor > FAC_W'(MAX_FACTOR)) begin
            fac = FAC_W'(MAX_FACTOR);
        end else begin
            fac = r_factor;
        end

        if (r_width == '0) begin
            w_m1 = '0;
        end else if (r_width > CFG_W'(MAX_SIDE)) begin
            w_m1 = POS_W'(MAX_SIDE - 1);
        end else begin
            w_m1 = POS_W'(r_width - CFG_W'(1));
        end

        if (r_height == '0) begin
            h_m1 = '0;
        end else if (r_height > CFG_W'(MAX_SIDE)) begin
            h_m1 = POS_W'(MAX_SIDE - 1);
        end else begin
            h_m1 = POS_W'(r_height - CFG_W'(1));
        end
    end

    assign fac_m1     = SUB_W'(fac - FAC_W'(1));
    assign col_last   = r_sub_col >= fac_m1;
    assign row_last   = r_sub_row >= fac_m1;
    assign line_end   = r_src_col >= w_m1;
    assign frame_last = line_end && (r_src_row >= h_m1);

    assign o_factor         = fac;
    assign o_tag.act        = !r_out_over;
    assign o_tag.last       = col_last && row_last;
    assign o_tag.frame_last = frame_last;
    assign o_tag.clear      = line_end && (row_last || frame_last);
    assign o_tag.col        = r_out_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= FACTOR_RESET;
            r_width  <= SIDE_RESET;
            r_height <= SIDE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SCALE:  r_factor <= i_cfg_data[FAC_W-1:0];
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col  <= '0;
            r_src_row  <= '0;
            r_sub_col  <= '0;
            r_sub_row  <= '0;
            r_out_col  <= '0;
            r_out_over <= 1'b0;
        end else if (i_step) begin
            if (line_end) begin
                r_src_col  <= '0;
                r_sub_col  <= '0;
                r_out_col  <= '0;
                r_out_over <= 1'b0;
                r_sub_row  <= (row_last || frame_last) ? '0 : r_sub_row + SUB_W'(1);
                r_src_row  <= frame_last ? '0 : r_src_row + POS_W'(1);
            end else begin
                r_src_col <= r_src_col + POS_W'(1);
                if (col_last) begin
                    r_sub_col <= '0;
                    if (&r_out_col) begin
                        r_out_over <= 1'b1;
                    end else begin
                        r_out_col <= r_out_col + COL_W'(1);
                    end
                end else begin
                    r_sub_col <= r_sub_col + SUB_W'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bfd_lane.sv =====
// One color channel: accumulator add, then divide by factor squared via reciprocal multiply.
// Depends on bfd_pkg.
`default_nettype none

module bfd_lane (
    input  logic                        i_clk,
    input  logic                        i_load_b,
    input  logic [bfd_pkg::PIX_W-1:0]   i_pix,
    input  logic [bfd_pkg::SUM_W-1:0]   i_old,
    input  logic                        i_load_c,
    input  logic                        i_load_d,
    input  logic [bfd_pkg::FAC_W-1:0]   i_factor,
    output logic [bfd_pkg::SUM_W-1:0]   o_sum,
    output logic [bfd_pkg::PIX_W-1:0]   o_avg
);
    import bfd_pkg::*;

    logic [PIX_W-1:0]   r_pix;
    logic [SUM_W-1:0]   r_sum;
    logic [PIX_W-1:0]   r_avg;
    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0]  prod;

    assign o_sum = i_old + SUM_W'(r_pix);
    assign recip = recip_of(i_factor);
    assign prod  = PROD_W'(r_sum) * PROD_W'(recip);
    assign o_avg = r_avg;

    always_ff @(posedge i_clk) begin
        if (i_load_b) begin
            r_pix <= i_pix;
        end
        if (i_load_c) begin
            r_sum <= o_sum;
        end
        if (i_load_d) begin
            // low byte of the quotient
            r_avg <= prod[RECIP_SHIFT +: PIX_W];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/box_filter_downsample.sv =====
// Box filter downsampler top level: position control, column accumulator RAM, three lanes.
// Depends on bfd_pkg, bfd_pix_if, bfd_avg_if, bfd_ram, bfd_ctrl, bfd_lane.
//
//  Port        Dir  Handshake    Word
//  ----------  ---  -----------  ------------------------------------------------
//  i_pix       in   valid/ready  pixel_red, pixel_green, pixel_blue (raster order)
//  o_avg       out  valid/ready  avg_red, avg_green, avg_blue, frame_end
//  i_cfg_*     in   write only   idx 0 scale_factor, 1 source_width, 2 source_height
//
// Takes one pixel per clock unless o_avg back-pressure stalls it as described below.
// A block sum ends in B; the reciprocal multiply from C into D presents it on o_avg.
// Per-column valid flops stand in for clearing the accumulator RAM, so there is no
// clearing pass: the block accepts words from the first cycle after reset.
// A word held at o_avg stalls the input only once C also holds a result and the
// word in B closes a block.
`default_nettype none

module box_filter_downsample (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bfd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bfd_pkg::CFG_W-1:0]     i_cfg_data,
    bfd_pix_if.sink                       i_pix,
    bfd_avg_if.source                     o_avg
);
    import bfd_pkg::*;

    // Pipeline:
    //   accept : position tag from ctrl, RAM read of the column's sums
    //   B      : old sums (RAM, forwarded or zero) + pixel, write back
    //   C      : sums of a finished block wait for the multiplier
    //   D      : quotient registered, presented on o_avg

    t_tag             tag_in;
    t_tag             r_b_tag;
    logic             r_b_valid;
    logic             r_c_valid;
    logic             r_d_valid;
    logic             r_c_fe;
    logic             r_d_fe;
    logic             r_b_fwd_hit;
    logic [SUM_ALL_W-1:0] r_b_fwd_data;
    logic [MAX_OUT_WIDTH-1:0] r_vld;

    logic             accept;
    logic             b_res;
    logic             b_move;
    logic             c_move;
    logic             load_c;
    logic [FAC_W-1:0] factor;
    logic [SUM_ALL_W-1:0] ram_q;
    logic [SUM_ALL_W-1:0] old_all;
    logic [SUM_ALL_W-1:0] new_all;
    logic [SUM_ALL_W-1:0] wval;
    logic [PIX_W-1:0] pix_ch [NUM_CH];
    logic [PIX_W-1:0] avg_ch [NUM_CH];

    bfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_step     (accept),
        .o_tag      (tag_in),
        .o_factor   (factor)
    );

    // ---- handshake and stage movement ----
    assign b_res  = r_b_tag.act && r_b_tag.last;
    assign c_move = r_c_valid && (!r_d_valid || o_avg.ready);
    assign b_move = r_b_valid && (!b_res || !r_c_valid || c_move);
    assign load_c = b_move && b_res;

    assign i_pix.ready = !r_b_valid || b_move;
    assign accept      = i_pix.valid && i_pix.ready;

    // ---- accumulator RAM, one entry per output column, three channel sums ----
    bfd_ram #(
        .WIDTH (SUM_ALL_W),
        .DEPTH (MAX_OUT_WIDTH)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (b_move && r_b_tag.act),
        .i_waddr (r_b_tag.col),
        .i_wdata (wval),
        .i_re    (accept),
        .i_raddr (tag_in.col),
        .o_rdata (ram_q)
    );

    // Entry written on the same edge as our read: RAM returns stale data, use the
    // registered copy. A column never written since the last clear reads as zero.
    assign old_all = r_b_fwd_hit ? r_b_fwd_data :
                     (r_vld[r_b_tag.col] ? ram_q : '0);

    // finished block or block row end leaves the entry at zero
    assign wval = (r_b_tag.last || r_b_tag.clear) ? '0 : new_all;

    // ---- channel lanes ----
    assign pix_ch[0] = i_pix.pixel_red;
    assign pix_ch[1] = i_pix.pixel_green;
    assign pix_ch[2] = i_pix.pixel_blue;

    for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
        bfd_lane u_lane (
            .i_clk    (i_clk),
            .i_load_b (accept),
            .i_pix    (pix_ch[ch]),
            .i_old    (old_all[ch*SUM_W +: SUM_W]),
            .i_load_c (load_c),
            .i_load_d (c_move),
            .i_factor (factor),
            .o_sum    (new_all[ch*SUM_W +: SUM_W]),
            .o_avg    (avg_ch[ch])
        );
    end

    // ---- merge: output word ----
    assign o_avg.valid     = r_d_valid;
    assign o_avg.avg_red   = avg_ch[0];
    assign o_avg.avg_green = avg_ch[1];
    assign o_avg.avg_blue  = avg_ch[2];
    assign o_avg.frame_end = r_d_fe;

    // ---- control registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_b_fwd_hit <= 1'b0;
            r_vld       <= '0;
        end else begin
            if (accept) begin
                r_b_valid   <= 1'b1;
                r_b_fwd_hit <= b_move &&
                               (r_b_tag.clear || (r_b_tag.act && r_b_tag.col == tag_in.col));
            end else if (b_move) begin
                r_b_valid <= 1'b0;
            end

            if (load_c) begin
                r_c_valid <= 1'b1;
            end else if (c_move) begin
                r_c_valid <= 1'b0;
            end

            if (c_move) begin
                r_d_valid <= 1'b1;
            end else if (o_avg.ready) begin
                r_d_valid <= 1'b0;
            end

            if (b_move) begin
                if (r_b_tag.clear) begin
                    r_vld <= '0;
                end else if (r_b_tag.act) begin
                    r_vld[r_b_tag.col] <= 1'b1;
                end
            end
        end
    end

    // ---- payload registers ----
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_tag      <= tag_in;
            r_b_fwd_data <= wval;
        end
        if (load_c) begin
            r_c_fe <= r_b_tag.frame_last;
        end
        if (c_move) begin
            r_d_fe <= r_c_fe;
        end
    end

    // ---- assertions ----
    a_accept_fills_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_b_valid)
        else $error("accepted word did not reach stage B");

    a_result_fills_c: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_move && b_res) |=> r_c_valid)
        else $error("finished block lost between B and C");

    a_clear_drops_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_move && r_b_tag.clear) |=> (r_vld == '0))
        else $error("column valid bits survive a block row end");

endmodule

`default_nettype wire
